// ===== rtl/core/itf_pkg.sv =====
// ----------------------------------------------------------------------------
// itf_pkg
// Shared types, codes and character constants of the integer-to-text formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package itf_pkg;

  localparam int unsigned MaxWidthDefault = 62;
  localparam int unsigned QueueDepthDefault = 2;

  // digit slots: 22 octal digits cover 64 bits, 20 decimal digits, 16 hex
  localparam int unsigned NumDigits = 22;
  localparam int unsigned DigitBits = 4 * NumDigits;

  typedef enum logic [2:0] {
    SZ_CHAR  = 3'd0,
    SZ_SHORT = 3'd1,
    SZ_INT   = 3'd2,
    SZ_LONG  = 3'd3,
    SZ_LLONG = 3'd4
  } itf_size_e;

  typedef enum logic [2:0] {
    CONV_SDEC = 3'd0,
    CONV_UDEC = 3'd1,
    CONV_OCT  = 3'd2,
    CONV_HEX  = 3'd3,
    CONV_PTR  = 3'd4
  } itf_conv_e;

  typedef enum logic [1:0] {
    BASE_DEC,
    BASE_OCT,
    BASE_HEX
  } itf_base_e;

  typedef enum logic [1:0] {
    PFX_NONE,
    PFX_ZERO,
    PFX_ZEROX
  } itf_pfx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CONV,
    BK_COUNT,
    BK_PREFIX,
    BK_PAD,
    BK_SIGN,
    BK_DIGIT
  } itf_bk_state_e;

  typedef struct packed {
    logic [63:0] mag;
    logic        neg;
    itf_base_e   base;
    itf_pfx_e    pfx;
    logic        zero_pad;
    logic [5:0]  width;
  } itf_job_t;

  localparam logic [6:0] ChZero    = 7'h30;
  localparam logic [6:0] ChX       = 7'h78;
  localparam logic [6:0] ChSpace   = 7'h20;
  localparam logic [6:0] ChMinus   = 7'h2D;
  localparam logic [6:0] ChAlphaLo = 7'h37; // 'A' - 10

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    if (d > 4'd9) begin
      c = ChAlphaLo + {3'b000, d};
    end else begin
      c = ChZero + {3'b000, d};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/itf_front.sv =====
// ----------------------------------------------------------------------------
// itf_front
// Request classifier: size truncation, sign handling, base and prefix choice.
// ----------------------------------------------------------------------------
`default_nettype none

module itf_front #(
  parameter int unsigned MAX_WIDTH = itf_pkg::MaxWidthDefault
) (
  input  wire logic [63:0]     value_i,
  input  wire logic [2:0]      size_code_i,
  input  wire logic [2:0]      conversion_i,
  input  wire logic            alt_form_i,
  input  wire logic            zero_pad_i,
  input  wire logic [5:0]      field_width_i,
  output itf_pkg::itf_job_t    job_o
);
  import itf_pkg::*;

  localparam logic [5:0] MaxW = 6'(MAX_WIDTH);

  itf_conv_e   conv;
  logic        sgn;
  logic [63:0] ext;

  always_comb begin
    case (itf_conv_e'(conversion_i))
      CONV_SDEC, CONV_UDEC, CONV_OCT, CONV_HEX, CONV_PTR: conv = itf_conv_e'(conversion_i);
      default: conv = CONV_UDEC;
    endcase
  end

  assign sgn = (conv == CONV_SDEC);

  always_comb begin
    if (conv == CONV_PTR) begin
      ext = {32'b0, value_i[31:0]};
    end else begin
      case (itf_size_e'(size_code_i))
        SZ_CHAR:        ext = {{56{sgn & value_i[7]}}, value_i[7:0]};
        SZ_SHORT:       ext = {{48{sgn & value_i[15]}}, value_i[15:0]};
        SZ_INT, SZ_LONG: ext = {{32{sgn & value_i[31]}}, value_i[31:0]};
        default:        ext = value_i;
      endcase
    end
  end

  always_comb begin
    job_o.neg      = sgn & ext[63];
    job_o.mag      = job_o.neg ? (64'd0 - ext) : ext;
    job_o.zero_pad = zero_pad_i;
    job_o.width    = (field_width_i > MaxW) ? MaxW : field_width_i;
    case (conv)
      CONV_OCT:           job_o.base = BASE_OCT;
      CONV_HEX, CONV_PTR: job_o.base = BASE_HEX;
      default:            job_o.base = BASE_DEC;
    endcase
    if (conv == CONV_PTR || (alt_form_i && conv == CONV_HEX)) begin
      job_o.pfx = PFX_ZEROX;
    end else if (alt_form_i && conv == CONV_OCT) begin
      job_o.pfx = PFX_ZERO;
    end else begin
      job_o.pfx = PFX_NONE;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/itf_queue.sv =====
// ----------------------------------------------------------------------------
// itf_queue
// Short job queue between the classifier and the text generator.
// ----------------------------------------------------------------------------
`default_nettype none

module itf_queue #(
  parameter int unsigned DEPTH = itf_pkg::QueueDepthDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire itf_pkg::itf_job_t job_i,
  output logic                   full_o,
  output logic                   nonempty_o,
  input  wire logic              pop_i,
  output itf_pkg::itf_job_t      job_o
);
  import itf_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  itf_job_t          mem_q [DEPTH];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(DEPTH));
  assign nonempty_o = (cnt_q != '0);
  assign job_o      = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/itf_back.sv =====
// ----------------------------------------------------------------------------
// itf_back
// Text generator: digit extraction (4-bit-per-cycle double dabble for
// decimal), digit count, then one character beat per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module itf_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              job_valid_i,
  input  wire itf_pkg::itf_job_t job_i,
  output logic                   job_pop_o,
  output logic                   char_valid_o,
  output logic [6:0]             char_out_o,
  output logic                   last_char_o
);
  import itf_pkg::*;

  localparam int unsigned ConvSteps = 16; // 64 bits, 4 per cycle

  itf_bk_state_e        state_q, state_d;
  itf_job_t             job_q, job_d;
  logic [63:0]          bin_q, bin_d;
  logic [DigitBits-1:0] dig_q, dig_d;
  logic [5:0]           cnt_q, cnt_d;
  logic [4:0]           nd_q, nd_d;
  logic [5:0]           pad_q, pad_d;
  logic                 ov_q, ov_d, ol_q, ol_d;
  logic [6:0]           oc_q, oc_d;

  logic [DigitBits-1:0] dd_dig, slice_oct, slice_hex;
  logic [63:0]          dd_bin;
  logic [4:0]           nd_c;
  logic [5:0]           body_c, pad_c;
  logic [3:0]           digit_sel;
  itf_bk_state_e        after_pad;

  // four double-dabble steps per cycle
  always_comb begin
    dd_dig = dig_q;
    dd_bin = bin_q;
    for (int s = 0; s < 4; s++) begin
      for (int i = 0; i < NumDigits; i++) begin
        if (dd_dig[4*i +: 4] >= 4'd5) begin
          dd_dig[4*i +: 4] = dd_dig[4*i +: 4] + 4'd3;
        end
      end
      dd_dig = {dd_dig[DigitBits-2:0], dd_bin[63]};
      dd_bin = {dd_bin[62:0], 1'b0};
    end
  end

  always_comb begin
    slice_hex = '0;
    slice_oct = '0;
    for (int i = 0; i < 16; i++) begin
      slice_hex[4*i +: 4] = job_i.mag[4*i +: 4];
    end
    for (int i = 0; i < 21; i++) begin
      slice_oct[4*i +: 4] = {1'b0, job_i.mag[3*i +: 3]};
    end
    slice_oct[4*21 +: 4] = {3'b000, job_i.mag[63]};
  end

  always_comb begin
    nd_c = 5'd1;
    for (int i = 0; i < NumDigits; i++) begin
      if (dig_q[4*i +: 4] != 4'd0) begin
        nd_c = 5'(i + 1);
      end
    end
    body_c = {1'b0, nd_c} + {5'b0, job_q.neg};
    pad_c  = (job_q.width > body_c) ? (job_q.width - body_c) : 6'd0;
  end

  assign digit_sel = dig_q[{cnt_q[4:0], 2'b00} +: 4];
  assign after_pad = job_q.neg ? BK_SIGN : BK_DIGIT;

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    bin_d     = bin_q;
    dig_d     = dig_q;
    cnt_d     = cnt_q;
    nd_d      = nd_q;
    pad_d     = pad_q;
    ov_d      = 1'b0;
    ol_d      = 1'b0;
    oc_d      = oc_q;
    job_pop_o = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          cnt_d     = '0;
          if (job_i.base == BASE_DEC) begin
            bin_d   = job_i.mag;
            dig_d   = '0;
            state_d = BK_CONV;
          end else begin
            dig_d   = (job_i.base == BASE_HEX) ? slice_hex : slice_oct;
            state_d = BK_COUNT;
          end
        end
      end
      BK_CONV: begin
        dig_d = dd_dig;
        bin_d = dd_bin;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(ConvSteps - 1)) begin
          state_d = BK_COUNT;
        end
      end
      BK_COUNT: begin
        nd_d  = nd_c;
        pad_d = pad_c;
        if (job_q.pfx != PFX_NONE) begin
          cnt_d   = '0;
          state_d = BK_PREFIX;
        end else begin
          cnt_d   = {1'b0, nd_c} - 6'd1;
          state_d = (pad_c != 6'd0) ? BK_PAD : after_pad;
        end
      end
      BK_PREFIX: begin
        ov_d = 1'b1;
        oc_d = (job_q.pfx == PFX_ZEROX && cnt_q[0]) ? ChX : ChZero;
        if (job_q.pfx == PFX_ZERO || cnt_q[0]) begin
          cnt_d   = {1'b0, nd_q} - 6'd1;
          state_d = (pad_q != 6'd0) ? BK_PAD : after_pad;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      BK_PAD: begin
        ov_d  = 1'b1;
        oc_d  = job_q.zero_pad ? ChZero : ChSpace;
        pad_d = pad_q - 6'd1;
        if (pad_q == 6'd1) begin
          state_d = after_pad;
        end
      end
      BK_SIGN: begin
        ov_d    = 1'b1;
        oc_d    = ChMinus;
        state_d = BK_DIGIT;
      end
      BK_DIGIT: begin
        ov_d = 1'b1;
        oc_d = digit_char(digit_sel);
        if (cnt_q == 6'd0) begin
          ol_d    = 1'b1;
          state_d = BK_IDLE;
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      ov_q    <= 1'b0;
      ol_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      ol_q    <= ol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    bin_q <= bin_d;
    dig_q <= dig_d;
    cnt_q <= cnt_d;
    nd_q  <= nd_d;
    pad_q <= pad_d;
    oc_q  <= oc_d;
  end

  assign char_valid_o = ov_q;
  assign char_out_o   = oc_q;
  assign last_char_o  = ol_q;

endmodule

`default_nettype wire

// ===== rtl/core/integer_to_text_formatter.sv =====
// ----------------------------------------------------------------------------
// integer_to_text_formatter
// printf-style integer conversion: one request in, a stream of ASCII out.
// ----------------------------------------------------------------------------
// Request channel: a request beat is taken on a rising edge with start high
// and busy low; busy rises while the two-entry request queue is full.
// Result channel: each character is on char_out_o for one cycle with
// char_valid_o high; last_char_o marks the final character of a request.
// There is no back-pressure: the consumer takes every character as it comes.
// Characters of one request leave on consecutive cycles with no gaps.
// Per request, the generator loads the job, runs double dabble for decimal
// (none for octal/hex), counts the digits, then emits one character per
// cycle. It takes the next request from the queue only after the last
// character of the current one has been emitted.
// Up to two requests wait in the queue while one is being printed.
// Reset clears the queue and the generator; no output follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_text_formatter #(
  parameter int unsigned MAX_WIDTH   = itf_pkg::MaxWidthDefault,
  parameter int unsigned QUEUE_DEPTH = itf_pkg::QueueDepthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] value_i,
  input  wire logic [2:0]  size_code_i,
  input  wire logic [2:0]  conversion_i,
  input  wire logic        alt_form_i,
  input  wire logic        zero_pad_i,
  input  wire logic [5:0]  field_width_i,
  output logic             char_valid_o,
  output logic [6:0]       char_out_o,
  output logic             last_char_o
);
  import itf_pkg::*;

  itf_job_t front_job, queue_job;
  logic     push, full, nonempty, pop;

  assign busy = full;
  assign push = start & ~full;

  itf_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .value_i      (value_i),
    .size_code_i  (size_code_i),
    .conversion_i (conversion_i),
    .alt_form_i   (alt_form_i),
    .zero_pad_i   (zero_pad_i),
    .field_width_i(field_width_i),
    .job_o        (front_job)
  );

  itf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .job_i     (front_job),
    .full_o    (full),
    .nonempty_o(nonempty),
    .pop_i     (pop),
    .job_o     (queue_job)
  );

  itf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (nonempty),
    .job_i       (queue_job),
    .job_pop_o   (pop),
    .char_valid_o(char_valid_o),
    .char_out_o  (char_out_o),
    .last_char_o (last_char_o)
  );

  a_beat_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> nonempty)
    else $error("accepted request beat not in queue");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> nonempty)
    else $error("pop from empty queue");

  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_valid_o && !last_char_o) |=> char_valid_o)
    else $error("gap inside a conversion");

  a_last_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_char_o |-> char_valid_o)
    else $error("last flag without strobe");

endmodule

`default_nettype wire
